### design/spherical_point_rotator_assert.svh
// Assertion macros shared by the spherical point rotator modules.
// Each file that asserts includes this header; the assertions drop out under SYNTH.
`ifndef SPHERICAL_POINT_ROTATOR_ASSERT_SVH
`define SPHERICAL_POINT_ROTATOR_ASSERT_SVH
`ifndef SYNTH
`define SPR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPR_ASSERT_IMP(lbl, ante, cons, msg)
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/spr_pkg.sv
// Package of the spherical point rotator: item kinds, state types, CORDIC constants.
// No dependencies; used by spr_cordic and spherical_point_rotator.
package spr_pkg;

    typedef enum logic [1:0] {
        KIND_SET,
        KIND_ROT_X,
        KIND_ROT_Y,
        KIND_ROT_Z
    } t_kind;

    typedef enum logic [1:0] {
        C_IDLE,
        C_STEP,
        C_GAIN
    } t_cst;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REF,
        S_REF1_GO,
        S_REF1_WAIT,
        S_REF2_GO,
        S_REF2_WAIT,
        S_ROT_GO,
        S_ROT_WAIT,
        S_AZ_GO,
        S_AZ_WAIT,
        S_POL_GO,
        S_POL_WAIT,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic vec;
    } t_cordic_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_sts;

    localparam int GAIN_BITS = 20;
    localparam logic [GAIN_BITS-1:0] GAIN_Q20 = 20'd636752;
    localparam logic [31:0] TURN_HALF  = 32'h8000_0000;
    localparam logic [31:0] TURN_QUART = 32'h4000_0000;

    function automatic logic [31:0] atan_ent(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### design/spherical_point_rotator.sv
// Spherical point rotator: holds one point as radius, polar angle and azimuth with a
// cached Cartesian copy; set, rotate about x, y or z, and return the refreshed point.
// Depends on spr_pkg and spr_cordic.
//
// One item is worked at a time on a single shared CORDIC unit. Each CORDIC pass runs
// through the start cycle, the micro-rotations, 20 serial gain bits and then the
// handoff. A set item uses up to two vectoring passes and two rotation passes; a
// rotation about x or y uses up to two rebuild passes, one rotation pass and up to two
// vectoring passes; a rotation about z uses at most two rebuild passes. The result
// waits in an output register, so a new item can be taken while it is pending.
`include "spherical_point_rotator_assert.svh"
module spherical_point_rotator import spr_pkg::*; #(
    parameter int COORD_WIDTH  = 24,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // x_in, y_in, z_in, angle from the lowest bit up.
    input  logic [((3*COORD_WIDTH+ANGLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // kind.
    input  logic [1:0]          i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // x_out, y_out, z_out, radius_out, polar_out, azimuth_out from the lowest bit up.
    output logic [((3*COORD_WIDTH+6+COORD_WIDTH+1+2*ANGLE_BITS+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int CW      = COORD_WIDTH;
    localparam int AB      = ANGLE_BITS;
    localparam int CART_W  = CW + 2;
    localparam int RAD_W   = CW + 1;
    localparam int EXTRA   = 6;
    localparam int W       = CW + 12;
    localparam int OUT_B   = 3 * CART_W + RAD_W + 2 * AB;
    localparam int OUT_W   = ((OUT_B + 7) / 8) * 8;
    localparam logic [AB-1:0] ANG_HALF = AB'(1) << (AB - 1);

    function automatic logic signed [W-1:0] ext_c(input logic signed [CART_W-1:0] v);
        return $signed({{(W-CART_W-EXTRA){v[CART_W-1]}}, v, {EXTRA{1'b0}}});
    endfunction

    function automatic logic signed [W-1:0] from_ext(input logic signed [W-1:0] v);
        logic signed [W-1:0] s;
        s = v + W'(1 << (EXTRA - 1));
        return s >>> EXTRA;
    endfunction

    function automatic logic signed [CART_W-1:0] sat_c(input logic signed [W-1:0] v);
        logic signed [W-1:0] hi;
        logic signed [W-1:0] lo;
        hi = W'((64'sd1 <<< (CART_W - 1)) - 64'sd1);
        lo = -hi - W'(1);
        if (v > hi) begin
            return CART_W'(hi);
        end else if (v < lo) begin
            return CART_W'(lo);
        end
        return CART_W'(v);
    endfunction

    function automatic logic [31:0] to32(input logic [AB-1:0] a);
        return {a, {(32-AB){1'b0}}};
    endfunction

    function automatic logic [AB-1:0] from32(input logic [31:0] u);
        logic [31:0] s;
        s = u + (32'd1 << (31 - AB));
        return s[31:32-AB];
    endfunction

    t_state                   r_state, n_state;
    logic [RAD_W-1:0]         r_radius, n_radius;
    logic [AB-1:0]            r_polar, n_polar, r_az, n_az;
    logic signed [CART_W-1:0] r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic                     r_stale, n_stale;
    t_kind                    r_kind, n_kind;
    logic [AB-1:0]            r_ang, n_ang;
    logic                     r_pre, n_pre;
    logic signed [W-1:0]      r_mag, n_mag, r_tz, n_tz;
    logic                     r_ovalid, n_ovalid;
    logic [OUT_W-1:0]         r_odata, n_odata;

    t_cordic_ctl              w_ctl;
    t_cordic_sts              w_sts;
    logic signed [W-1:0]      w_ca, w_cb, w_ra, w_rb;
    logic [31:0]              w_cang, w_racc;

    spr_cordic #(
        .W     (W),
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_ca),
        .i_b     (w_cb),
        .i_ang   (w_cang),
        .o_sts   (w_sts),
        .o_a     (w_ra),
        .o_b     (w_rb),
        .o_acc   (w_racc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_radius <= '0;
            r_polar  <= '0;
            r_az     <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_stale  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_radius <= n_radius;
            r_polar  <= n_polar;
            r_az     <= n_az;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_cz     <= n_cz;
            r_stale  <= n_stale;
            r_ovalid <= n_ovalid;
        end
        r_kind  <= n_kind;
        r_ang   <= n_ang;
        r_pre   <= n_pre;
        r_mag   <= n_mag;
        r_tz    <= n_tz;
        r_odata <= n_odata;
    end

    always_comb begin
        logic [AB-1:0]       v_phi;
        logic [31:0]         v_u;
        logic signed [W-1:0] v_r;
        logic signed [W-1:0] v_zc;
        n_state  = r_state;
        n_radius = r_radius;
        n_polar  = r_polar;
        n_az     = r_az;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_cz     = r_cz;
        n_stale  = r_stale;
        n_kind   = r_kind;
        n_ang    = r_ang;
        n_pre    = r_pre;
        n_mag    = r_mag;
        n_tz     = r_tz;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        w_ctl    = '0;
        w_ca     = '0;
        w_cb     = '0;
        w_cang   = '0;
        v_phi    = (r_polar == '0 || r_polar == ANG_HALF) ? '0 : r_az;
        v_u      = w_racc;
        v_r      = from_ext(r_mag);
        v_zc     = ext_c(r_cz);
        o_s_axis_tready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_kind = t_kind'(i_s_axis_tuser);
                    n_ang  = i_s_axis_tdata[3*CW+AB-1:3*CW];
                    n_pre  = 1'b0;
                    n_state = S_REF;
                    case (t_kind'(i_s_axis_tuser))
                        KIND_SET: begin
                            n_cx = CART_W'($signed(i_s_axis_tdata[CW-1:0]));
                            n_cy = CART_W'($signed(i_s_axis_tdata[2*CW-1:CW]));
                            n_cz = CART_W'($signed(i_s_axis_tdata[3*CW-1:2*CW]));
                            n_stale = 1'b1;
                            if (i_s_axis_tdata[3*CW-1:0] == '0) begin
                                n_radius = '0;
                                n_polar  = '0;
                                n_az     = '0;
                            end else begin
                                n_state = S_AZ_GO;
                            end
                        end
                        KIND_ROT_X, KIND_ROT_Y: begin
                            n_pre = 1'b1;
                        end
                        KIND_ROT_Z: begin
                            if (i_s_axis_tdata[3*CW+AB-1:3*CW] != '0) begin
                                n_az    = r_az + i_s_axis_tdata[3*CW+AB-1:3*CW];
                                n_stale = 1'b1;
                            end
                        end
                        default: begin
                            n_pre = 1'b0;
                        end
                    endcase
                end
            end
            S_REF: begin
                if (r_stale) begin
                    n_state = S_REF1_GO;
                end else if (r_pre) begin
                    n_state = S_ROT_GO;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_REF1_GO, S_REF1_WAIT: begin
                w_ctl.start = (r_state == S_REF1_GO);
                w_ca   = $signed({{(W-RAD_W-EXTRA){1'b0}}, r_radius, {EXTRA{1'b0}}});
                w_cang = to32(r_polar);
                if (r_state == S_REF1_GO) begin
                    n_state = S_REF1_WAIT;
                end else if (w_sts.done) begin
                    n_tz    = w_ra;
                    n_mag   = w_rb;
                    n_state = S_REF2_GO;
                end
            end
            S_REF2_GO, S_REF2_WAIT: begin
                w_ctl.start = (r_state == S_REF2_GO);
                w_ca   = r_mag;
                w_cang = to32(v_phi);
                if (r_state == S_REF2_GO) begin
                    n_state = S_REF2_WAIT;
                end else if (w_sts.done) begin
                    n_cx    = sat_c(from_ext(w_ra));
                    n_cy    = sat_c(from_ext(w_rb));
                    n_cz    = sat_c(from_ext(r_tz));
                    n_stale = 1'b0;
                    n_state = r_pre ? S_ROT_GO : S_OUT;
                end
            end
            S_ROT_GO, S_ROT_WAIT: begin
                w_ctl.start = (r_state == S_ROT_GO);
                w_ca   = (r_kind == KIND_ROT_X) ? ext_c(r_cy) : ext_c(r_cz);
                w_cb   = (r_kind == KIND_ROT_X) ? ext_c(r_cz) : ext_c(r_cx);
                w_cang = to32(r_ang);
                if (r_state == S_ROT_GO) begin
                    n_state = S_ROT_WAIT;
                end else if (w_sts.done) begin
                    if (r_kind == KIND_ROT_X) begin
                        n_cy = sat_c(from_ext(w_ra));
                        n_cz = sat_c(from_ext(w_rb));
                    end else begin
                        n_cz = sat_c(from_ext(w_ra));
                        n_cx = sat_c(from_ext(w_rb));
                    end
                    n_pre = 1'b0;
                    if (r_radius == '0) begin
                        n_polar = '0;
                        n_az    = '0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_AZ_GO;
                    end
                end
            end
            S_AZ_GO, S_AZ_WAIT: begin
                w_ctl.start = (r_state == S_AZ_GO);
                w_ctl.vec   = 1'b1;
                w_ca   = ext_c(r_cx);
                w_cb   = ext_c(r_cy);
                if (r_state == S_AZ_GO) begin
                    n_state = S_AZ_WAIT;
                end else if (w_sts.done) begin
                    n_az = from32(w_racc);
                    if (w_ra == '0) begin
                        n_polar = r_cz[CART_W-1] ? ANG_HALF : '0;
                        n_mag   = r_cz[CART_W-1] ? -v_zc : v_zc;
                        n_state = S_FIN;
                    end else begin
                        n_mag   = w_ra;
                        n_state = S_POL_GO;
                    end
                end
            end
            S_POL_GO, S_POL_WAIT: begin
                w_ctl.start = (r_state == S_POL_GO);
                w_ctl.vec   = 1'b1;
                w_ca   = v_zc;
                w_cb   = r_mag;
                if (r_state == S_POL_GO) begin
                    n_state = S_POL_WAIT;
                end else if (w_sts.done) begin
                    if (w_racc > (TURN_HALF | TURN_QUART)) begin
                        v_u = '0;
                    end else if (w_racc > TURN_HALF) begin
                        v_u = TURN_HALF;
                    end
                    n_polar = from32(v_u);
                    n_mag   = w_ra;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_kind == KIND_SET) begin
                    if (v_r[W-1]) begin
                        n_radius = '0;
                    end else if (v_r > $signed({{(W-RAD_W){1'b0}}, {RAD_W{1'b1}}})) begin
                        n_radius = '1;
                    end else begin
                        n_radius = v_r[RAD_W-1:0];
                    end
                end
                n_pre   = 1'b0;
                n_state = S_REF;
            end
            S_OUT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_odata  = OUT_W'({r_az, r_polar, r_radius, r_cz, r_cy, r_cx});
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    `SPR_ASSERT_IMP(a_start_idle, w_ctl.start, !w_sts.busy, "CORDIC started while busy")
    `SPR_ASSERT_NEXT(a_one_item, (i_s_axis_tvalid && o_s_axis_tready), !o_s_axis_tready, "overlap")
    `SPR_ASSERT_IMP(a_polar_range, 1'b1, r_polar <= ANG_HALF, "polar angle beyond a half turn")

endmodule

### design/spr_cordic.sv
// Shared iterative CORDIC unit: one micro-rotation per cycle (none for a zero vector when vectoring),
// then a bit-serial gain correction that takes one multiplier bit per cycle. Depends on spr_pkg.
`include "spherical_point_rotator_assert.svh"
module spr_cordic import spr_pkg::*; #(
    parameter int W = 36,
    parameter int STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cordic_ctl         i_ctl,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    input  logic [31:0]         i_ang,
    output t_cordic_sts         o_sts,
    output logic signed [W-1:0] o_a,
    output logic signed [W-1:0] o_b,
    output logic [31:0]         o_acc
);

    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int GW = W + GAIN_BITS + 1;
    localparam int KW = $clog2(GAIN_BITS);

    t_cst                 r_st, n_st;
    logic signed [W-1:0]  r_a, n_a, r_b, n_b;
    logic signed [33:0]   r_z, n_z;
    logic                 r_vec, n_vec;
    logic [IW-1:0]        r_i, n_i;
    logic [KW-1:0]        r_k, n_k;
    logic signed [GW-1:0] r_ga, n_ga, r_gb, n_gb;
    logic                 r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= C_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_z   <= n_z;
        r_vec <= n_vec;
        r_i   <= n_i;
        r_k   <= n_k;
        r_ga  <= n_ga;
        r_gb  <= n_gb;
    end

    always_comb begin
        logic signed [W-1:0] v_da;
        logic signed [W-1:0] v_db;
        logic signed [33:0]  v_z;
        logic signed [33:0]  v_at;
        logic                v_pos;
        n_st   = r_st;
        n_a    = r_a;
        n_b    = r_b;
        n_z    = r_z;
        n_vec  = r_vec;
        n_i    = r_i;
        n_k    = r_k;
        n_ga   = r_ga;
        n_gb   = r_gb;
        n_done = 1'b0;
        v_da   = r_b >>> r_i;
        v_db   = r_a >>> r_i;
        v_at   = $signed({2'b00, atan_ent(5'(r_i))});
        v_z    = $signed({{2{i_ang[31]}}, i_ang});
        v_pos  = r_vec ? !r_b[W-1] : !r_z[33];
        case (r_st)
            C_IDLE: begin
                if (i_ctl.start) begin
                    n_vec = i_ctl.vec;
                    n_i   = '0;
                    n_k   = '0;
                    n_ga  = GW'(1) <<< (GAIN_BITS - 1);
                    n_gb  = GW'(1) <<< (GAIN_BITS - 1);
                    n_st  = C_STEP;
                    if (i_ctl.vec) begin
                        if (i_a == '0 && i_b == '0) begin
                            n_a  = '0;
                            n_b  = '0;
                            n_z  = '0;
                            n_st = C_GAIN;
                        end else if (i_a[W-1]) begin
                            n_a = -i_a;
                            n_b = -i_b;
                            n_z = $signed({2'b00, TURN_HALF});
                        end else begin
                            n_a = i_a;
                            n_b = i_b;
                            n_z = '0;
                        end
                    end else begin
                        if (v_z > $signed({2'b00, TURN_QUART})) begin
                            n_a = -i_a;
                            n_b = -i_b;
                            n_z = v_z - $signed({2'b00, TURN_HALF});
                        end else if (v_z < -$signed({2'b00, TURN_QUART})) begin
                            n_a = -i_a;
                            n_b = -i_b;
                            n_z = v_z + $signed({2'b00, TURN_HALF});
                        end else begin
                            n_a = i_a;
                            n_b = i_b;
                            n_z = v_z;
                        end
                    end
                end
            end
            C_STEP: begin
                if (r_vec) begin
                    if (v_pos) begin
                        n_a = r_a + v_da;
                        n_b = r_b - v_db;
                        n_z = r_z + v_at;
                    end else begin
                        n_a = r_a - v_da;
                        n_b = r_b + v_db;
                        n_z = r_z - v_at;
                    end
                end else begin
                    if (v_pos) begin
                        n_a = r_a - v_da;
                        n_b = r_b + v_db;
                        n_z = r_z - v_at;
                    end else begin
                        n_a = r_a + v_da;
                        n_b = r_b - v_db;
                        n_z = r_z + v_at;
                    end
                end
                n_i = r_i + 1'b1;
                if (r_i == IW'(STEPS - 1)) begin
                    n_st = C_GAIN;
                end
            end
            C_GAIN: begin
                if (GAIN_Q20[r_k]) begin
                    n_ga = r_ga + ($signed({{(GAIN_BITS+1){r_a[W-1]}}, r_a}) <<< r_k);
                    n_gb = r_gb + ($signed({{(GAIN_BITS+1){r_b[W-1]}}, r_b}) <<< r_k);
                end
                n_k = r_k + 1'b1;
                if (r_k == KW'(GAIN_BITS - 1)) begin
                    n_st   = C_IDLE;
                    n_done = 1'b1;
                end
            end
            default: begin
                n_st = C_IDLE;
            end
        endcase
    end

    assign o_a        = r_ga[W+GAIN_BITS-1:GAIN_BITS];
    assign o_b        = r_gb[W+GAIN_BITS-1:GAIN_BITS];
    assign o_acc      = r_z[31:0];
    assign o_sts.busy = (r_st != C_IDLE);
    assign o_sts.done = r_done;

    `SPR_ASSERT_IMP(a_done_idle, r_done, r_st == C_IDLE, "CORDIC done while still busy")
    `SPR_ASSERT_NEXT(a_start_runs, (i_ctl.start && r_st == C_IDLE), r_st != C_IDLE, "start lost")
    `SPR_ASSERT_IMP(a_gain_fresh, r_st == C_STEP, r_k == '0, "gain count not cleared")

endmodule
